[sv/cpa_pkg.sv]
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants for the cell projection accumulator.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int MAP_LEVEL_DEF   = 8;
  localparam int FIELD_COUNT_DEF = 4;

  // map coordinate counters: window extents never exceed 511
  localparam int CRD_W      = 10;
  // span arithmetic: offset plus cell edge (edge up to 2^15)
  localparam int SPAN_W     = 17;
  localparam int CMDQ_DEPTH = 2;
  localparam int PADDR_W    = 5;

  typedef enum logic [1:0] {
    OP_DEPOSIT = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_ORG_X = 3'd1,
    REG_ORG_Y = 3'd2,
    REG_ORG_Z = 3'd3,
    REG_EXT_X = 3'd4,
    REG_EXT_Y = 3'd5,
    REG_EXT_Z = 3'd6,
    REG_SCALE = 3'd7
  } reg_idx_t;

  typedef enum logic {
    MODE_MAX = 1'b0,
    MODE_AVG = 1'b1
  } proj_mode_t;

  typedef struct packed {
    proj_mode_t  mode;
    logic [7:0]  org_x;
    logic [7:0]  org_y;
    logic [7:0]  org_z;
    logic [8:0]  ext_x;
    logic [8:0]  ext_y;
    logic [8:0]  ext_z;
    logic [16:0] scale;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_DEPOSIT   = 2'd0,
    CMD_READ      = 2'd1,
    CMD_READ_ZERO = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_kind_t;

  // classified item; for a read, xs/ys hold the map column/row
  typedef struct packed {
    cmd_kind_t          kind;
    logic [1:0]         field;
    logic [CRD_W-1:0]   xs;
    logic [CRD_W-1:0]   xe;
    logic [CRD_W-1:0]   ys;
    logic [CRD_W-1:0]   ye;
    logic [8:0]         nz;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
    logic res_load;
    logic idle;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_MUL   = 3'd2,
    ST_SCALE = 3'd3,
    ST_RD    = 3'd4,
    ST_WR    = 3'd5,
    ST_READ  = 3'd6
  } back_state_t;

endpackage

[sv/cell_projection_accumulator.sv]
// ----------------------------------------------------------------------------
// cell_projection_accumulator
// Max / depth-average projection of cubic cells onto a per-field 2D map.
// ----------------------------------------------------------------------------
// Items enter through a push/full queue port: a deposit projects one cell,
// a read returns one map entry through the empty/pop result port, a clear
// zeroes the whole map. The front classifier culls and clips each deposit
// against the window in the cycle it arrives and drops items that change
// nothing; a two-entry command queue feeds the execution unit. That unit
// owns a single-port-write, registered-read map memory of
// FIELD_COUNT * 4^MAP_LEVEL words, so its cost is set by that one memory
// port: a read is one memory read, a deposit first runs its setup (scale
// multiply, then depth multiply) and then a read and a write for each covered
// map entry, and a clear writes zero to all FIELD_COUNT * 4^MAP_LEVEL words
// (262144 at the defaults). The same clearing sweep runs after reset, and
// full stays high until it finishes; configuration writes are taken at any
// time but should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module cell_projection_accumulator #(
  parameter int MAP_LEVEL   = cpa_pkg::MAP_LEVEL_DEF,
  parameter int FIELD_COUNT = cpa_pkg::FIELD_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // item input
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  opcode,
  input  logic [7:0]                  pos_x,
  input  logic [7:0]                  pos_y,
  input  logic [7:0]                  pos_z,
  input  logic [3:0]                  size_log2,
  input  logic [1:0]                  field_index,
  input  logic signed [31:0]          sample_value,
  // results
  output logic                        empty,
  input  logic                        pop,
  output logic signed [31:0]          read_value,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cpa_pkg::*;

  cfg_t       cfg;
  reg_idx_t   reg_sel;
  logic       cfg_we;
  cmd_t       front_cmd, q_cmd;
  logic       front_valid, q_full, q_valid, q_pop, q_push;
  back_stat_t stat;

  // register file: 4-byte stride
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_MAX;
      cfg.org_x <= '0;
      cfg.org_y <= '0;
      cfg.org_z <= '0;
      cfg.ext_x <= 9'd256;
      cfg.ext_y <= 9'd256;
      cfg.ext_z <= 9'd256;
      cfg.scale <= 17'd256;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_MODE:  cfg.mode  <= proj_mode_t'(pwdata[0]);
        REG_ORG_X: cfg.org_x <= pwdata[7:0];
        REG_ORG_Y: cfg.org_y <= pwdata[7:0];
        REG_ORG_Z: cfg.org_z <= pwdata[7:0];
        REG_EXT_X: cfg.ext_x <= pwdata[8:0];
        REG_EXT_Y: cfg.ext_y <= pwdata[8:0];
        REG_EXT_Z: cfg.ext_z <= pwdata[8:0];
        REG_SCALE: cfg.scale <= pwdata[16:0];
        default:   cfg.mode  <= cfg.mode;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:  prdata = {31'b0, cfg.mode};
      REG_ORG_X: prdata = {24'b0, cfg.org_x};
      REG_ORG_Y: prdata = {24'b0, cfg.org_y};
      REG_ORG_Z: prdata = {24'b0, cfg.org_z};
      REG_EXT_X: prdata = {23'b0, cfg.ext_x};
      REG_EXT_Y: prdata = {23'b0, cfg.ext_y};
      REG_EXT_Z: prdata = {23'b0, cfg.ext_z};
      REG_SCALE: prdata = {15'b0, cfg.scale};
      default:   prdata = '0;
    endcase
  end

  // front: cull, clip, classify; items that change nothing are dropped here
  cpa_front #(
    .MAP_LEVEL   (MAP_LEVEL),
    .FIELD_COUNT (FIELD_COUNT)
  ) u_front (
    .opcode       (opcode),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .size_log2    (size_log2),
    .field_index  (field_index),
    .sample_value (sample_value),
    .cfg          (cfg),
    .cmd          (front_cmd),
    .cmd_valid    (front_valid)
  );

  // no item taken during the post-reset clearing sweep
  assign full   = q_full || stat.init_busy;
  assign q_push = push && !full && front_valid;

  cpa_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_push),
    .wr_cmd    (front_cmd),
    .fifo_full (q_full),
    .rd_en     (q_pop),
    .rd_valid  (q_valid),
    .rd_cmd    (q_cmd)
  );

  // back: map memory, deposit walk, read port, clearing sweep
  cpa_back #(
    .MAP_LEVEL   (MAP_LEVEL),
    .FIELD_COUNT (FIELD_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .read_value (read_value),
    .stat       (stat)
  );

`ifndef ASSERT_OFF
  // a new result never lands on one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.res_load |-> empty)
    else $error("result overwritten before it was taken");

  // a result shows up only after the back unit loaded one
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(stat.res_load))
    else $error("result appeared without a load");

  // the back unit never sits idle with pending work while no result blocks it
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    (stat.idle && q_valid && empty) |-> q_pop)
    else $error("queued command not taken by idle back unit");
`endif

endmodule

[sv/cpa_front.sv]
// ----------------------------------------------------------------------------
// cpa_front
// Classifies an incoming item: culls and clips deposits, checks reads.
// ----------------------------------------------------------------------------
module cpa_front #(
  parameter int MAP_LEVEL   = cpa_pkg::MAP_LEVEL_DEF,
  parameter int FIELD_COUNT = cpa_pkg::FIELD_COUNT_DEF
) (
  input  logic [1:0]         opcode,
  input  logic [7:0]         pos_x,
  input  logic [7:0]         pos_y,
  input  logic [7:0]         pos_z,
  input  logic [3:0]         size_log2,
  input  logic [1:0]         field_index,
  input  logic signed [31:0] sample_value,
  input  cpa_pkg::cfg_t      cfg,
  output cpa_pkg::cmd_t      cmd,
  output logic               cmd_valid
);
  import cpa_pkg::*;

  localparam logic [SPAN_W-1:0] SIDE_S = SPAN_W'(1) << MAP_LEVEL;
  localparam logic [4:0]        FC_S   = 5'(FIELD_COUNT);

  function automatic logic in_window(logic [7:0] pos, logic [7:0] org, logic [8:0] ext);
    return (pos >= org) && ({2'b0, pos} <= ({2'b0, org} + {1'b0, ext}));
  endfunction

  logic [SPAN_W-1:0] side, lim_x, lim_y;
  logic [SPAN_W-1:0] sx, sy, sz, ex_full, ey_full, ez_full, ex, ey, ez;
  logic              field_ok, win_ok, dep_ok, map_ok;

  always_comb begin
    side     = SPAN_W'(1) << size_log2;
    lim_x    = ({8'b0, cfg.ext_x} < SIDE_S) ? {8'b0, cfg.ext_x} : SIDE_S;
    lim_y    = ({8'b0, cfg.ext_y} < SIDE_S) ? {8'b0, cfg.ext_y} : SIDE_S;
    sx       = SPAN_W'(pos_x - cfg.org_x);
    sy       = SPAN_W'(pos_y - cfg.org_y);
    sz       = SPAN_W'(pos_z - cfg.org_z);
    ex_full  = sx + side;
    ey_full  = sy + side;
    ez_full  = sz + side;
    ex       = (ex_full > lim_x) ? lim_x : ex_full;
    ey       = (ey_full > lim_y) ? lim_y : ey_full;
    ez       = (ez_full > {8'b0, cfg.ext_z}) ? {8'b0, cfg.ext_z} : ez_full;
    field_ok = {3'b0, field_index} < FC_S;
    win_ok   = in_window(pos_x, cfg.org_x, cfg.ext_x) &&
               in_window(pos_y, cfg.org_y, cfg.ext_y) &&
               in_window(pos_z, cfg.org_z, cfg.ext_z);
    // empty spans on any axis leave the map untouched
    dep_ok   = field_ok && win_ok && (ez > sz) && (ex > sx) && (ey > sy);
    map_ok   = field_ok && ({9'b0, pos_x} < SIDE_S) && ({9'b0, pos_y} < SIDE_S);

    cmd.field = field_index;
    cmd.value = sample_value;
    cmd.nz    = 9'(ez - sz);
    cmd.xe    = CRD_W'(ex);
    cmd.ye    = CRD_W'(ey);
    cmd.xs    = CRD_W'(sx);
    cmd.ys    = CRD_W'(sy);
    cmd.kind  = CMD_DEPOSIT;
    cmd_valid = 1'b0;
    case (opcode_t'(opcode))
      OP_DEPOSIT: begin
        cmd_valid = dep_ok;
      end
      OP_READ: begin
        cmd.xs    = CRD_W'(pos_x);
        cmd.ys    = CRD_W'(pos_y);
        cmd.kind  = map_ok ? CMD_READ : CMD_READ_ZERO;
        cmd_valid = 1'b1;
      end
      OP_CLEAR: begin
        cmd.kind  = CMD_CLEAR;
        cmd_valid = 1'b1;
      end
      default: cmd_valid = 1'b0;
    endcase
  end

endmodule

[sv/cpa_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// cpa_cmd_fifo
// Short command queue between classifier and execution unit.
// ----------------------------------------------------------------------------
module cpa_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  cpa_pkg::cmd_t wr_cmd,
  output logic          fifo_full,
  input  logic          rd_en,
  output logic          rd_valid,
  output cpa_pkg::cmd_t rd_cmd
);
  import cpa_pkg::*;

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          slots [CMDQ_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign fifo_full = (count == CW'(CMDQ_DEPTH));
  assign rd_valid  = (count != '0);
  assign rd_cmd    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_cmd;
    end
  end

endmodule

[sv/cpa_back.sv]
// ----------------------------------------------------------------------------
// cpa_back
// Execution unit: owns the projection map, walks deposits, serves reads.
// ----------------------------------------------------------------------------
module cpa_back #(
  parameter int MAP_LEVEL   = cpa_pkg::MAP_LEVEL_DEF,
  parameter int FIELD_COUNT = cpa_pkg::FIELD_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cpa_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  cpa_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] read_value,
  output cpa_pkg::back_stat_t stat
);
  import cpa_pkg::*;

  localparam int FW    = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;
  localparam int AW    = FW + 2 * MAP_LEVEL;
  localparam int DEPTH = FIELD_COUNT << (2 * MAP_LEVEL);
  localparam logic signed [44:0] SAT_HI = 45'sd2147483647;
  localparam logic signed [44:0] SAT_LO = -45'sd2147483648;

  function automatic logic [AW-1:0] addr_of(logic [1:0] f, logic [CRD_W-1:0] x,
                                            logic [CRD_W-1:0] y);
    logic [4:0]  fe;
    logic [15:0] x16, y16;
    fe  = {3'b0, f};
    x16 = 16'(x);
    y16 = 16'(y);
    return {fe[FW-1:0], y16[MAP_LEVEL-1:0], x16[MAP_LEVEL-1:0]};
  endfunction

  back_state_t        state, state_next;
  cmd_t               cur;
  logic [CRD_W-1:0]   x, y;
  logic [AW-1:0]      clr_cnt;
  logic               init_busy;
  logic signed [49:0] prod;
  logic signed [43:0] addv;
  logic               res_valid;

  logic signed [31:0] mem [0:DEPTH-1];
  logic signed [31:0] mem_q;
  logic [AW-1:0]      ra, wa;
  logic               we;
  logic signed [31:0] wd;
  logic               res_load;
  logic signed [31:0] res_data;
  logic               take;
  logic               last_x, last_y, clr_last;
  logic signed [33:0] term;
  logic signed [44:0] sum;

  always_comb begin
    take     = q_valid && (state == ST_IDLE) &&
               !(res_valid && (q_cmd.kind == CMD_READ || q_cmd.kind == CMD_READ_ZERO));
    last_x   = (x + 1'b1) == cur.xe;
    last_y   = (y + 1'b1) == cur.ye;
    clr_last = clr_cnt == AW'(DEPTH - 1);
    term     = 34'((prod + 50'sd32768) >>> 16);
    sum      = 45'(mem_q) + 45'(addv);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          case (q_cmd.kind)
            CMD_DEPOSIT: state_next = ST_MUL;
            CMD_READ:    state_next = ST_READ;
            CMD_CLEAR:   state_next = ST_CLEAR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_RD;
      ST_RD:    state_next = ST_WR;
      ST_WR:    state_next = (last_x && last_y) ? ST_IDLE : ST_RD;
      ST_READ:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = take;
    we       = 1'b0;
    wa       = addr_of(cur.field, x, y);
    wd       = '0;
    ra       = (state == ST_IDLE) ? addr_of(q_cmd.field, q_cmd.xs, q_cmd.ys)
                                  : addr_of(cur.field, x, y);
    res_load = 1'b0;
    res_data = mem_q;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt;
      end
      ST_IDLE: begin
        if (take && q_cmd.kind == CMD_READ_ZERO) begin
          res_load = 1'b1;
          res_data = '0;
        end
      end
      ST_WR: begin
        we = 1'b1;
        if (cfg.mode == MODE_MAX) begin
          wd = (cur.value > mem_q) ? cur.value : mem_q;
        end else if (sum > SAT_HI) begin
          wd = 32'sh7fffffff;
        end else if (sum < SAT_LO) begin
          wd = 32'sh80000000;
        end else begin
          wd = 32'(sum);
        end
      end
      ST_READ: res_load = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      init_busy <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + 1'b1;
        if (clr_last) init_busy <= 1'b0;
      end
      if (res_load) res_valid <= 1'b1;
      else if (pop) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_cmd;
      x   <= q_cmd.xs;
      y   <= q_cmd.ys;
    end else if (state == ST_WR && !(last_x && last_y)) begin
      if (last_x) begin
        x <= cur.xs;
        y <= y + 1'b1;
      end else begin
        x <= x + 1'b1;
      end
    end
    if (state == ST_MUL) prod <= cur.value * $signed({1'b0, cfg.scale});
    if (state == ST_SCALE) addv <= 44'(term) * 44'($signed({1'b0, cur.nz}));
    if (res_load) read_value <= res_data;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    mem_q <= mem[ra];
  end

  assign empty          = !res_valid;
  assign stat.init_busy = init_busy;
  assign stat.res_load  = res_load;
  assign stat.idle      = (state == ST_IDLE);

endmodule

[sim/cell_projection_accumulator_tb.sv]
// ----------------------------------------------------------------------------
// cell_projection_accumulator_tb
// Self-checking bench for the cell projection accumulator.
// ----------------------------------------------------------------------------
// A directed table covers the edge cases first. Random items follow across a
// set of window and mode settings. A local copy of the map predicts each read
// result not typed in; all compared in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module cell_projection_accumulator_tb;
  import cpa_pkg::*;

  localparam int MAP_SIDE   = 256;
  localparam int PLANE      = MAP_SIDE * MAP_SIDE;
  localparam int MAP_WORDS  = 4 * PLANE;
  // a clear sweeps 262144 words; a full-map deposit reads and writes 65536 entries
  localparam int IDLE_LIMIT = 700000;
  localparam int PHASE_ITEMS = 215;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic [1:0]         opcode = OP_DEPOSIT;
  logic [7:0]         pos_x = '0;
  logic [7:0]         pos_y = '0;
  logic [7:0]         pos_z = '0;
  logic [3:0]         size_log2 = '0;
  logic [1:0]         field_index = '0;
  logic signed [31:0] sample_value = '0;
  logic               pop = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic               full, empty, pready;
  logic signed [31:0] read_value;
  logic [31:0]        prdata;

  cell_projection_accumulator dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .opcode(opcode), .pos_x(pos_x), .pos_y(pos_y),
    .pos_z(pos_z), .size_log2(size_log2), .field_index(field_index),
    .sample_value(sample_value),
    .empty(empty), .pop(pop), .read_value(read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the map and the window registers
  logic signed [31:0] map_shadow [0:MAP_WORDS-1];
  logic        mode_sh;
  logic [7:0]  ox_sh, oy_sh, oz_sh;
  logic [8:0]  ex_sh, ey_sh, ez_sh;
  logic [16:0] scale_sh;

  logic signed [31:0] entry_q [$];   // read values still owed by the block
  int errors = 0;
  int last_xs = 0, last_ys = 0;      // start of the last covered square
  bit send_gaps = 1'b1;
  bit pop_gaps = 1'b1;
  bit hold_req = 1'b0;

  typedef struct {
    opcode_t     op;
    int          x, y, z, lg, fi;
    logic [31:0] val;
    bit          chk;     // expected value typed in below
    logic [31:0] expv;
  } row_t;

  typedef struct {
    logic        mode;
    int          ox, oy, oz, ex, ey, ez, scl;
    bit          big;     // window small enough for any cell size
    bit          gaps;
  } phase_t;

  // ---------------------------------------------------------------- predictor
  task automatic clear_shadow();
    for (int i = 0; i < MAP_WORDS; i++) map_shadow[i] = '0;
  endtask

  // clip one axis; returns 0 when the cell is culled
  function automatic bit clip_axis(input int p, input int org, input int ext,
                                   input int lim, input int side,
                                   output int s, output int e);
    s = 0;
    e = 0;
    if (p < org || p > org + ext) return 1'b0;
    s = p - org;
    e = s + side;
    if (e > lim) e = lim;
    return 1'b1;
  endfunction

  task automatic project_cell(input int x, input int y, input int z, input int lg,
                              input int fi, input logic signed [31:0] val);
    int side, xs, xe, ys, ye, zs, ze, limx, limy, nz, idx;
    longint term, add, sum;
    side = 1 << lg;
    limx = (ex_sh < MAP_SIDE) ? ex_sh : MAP_SIDE;
    limy = (ey_sh < MAP_SIDE) ? ey_sh : MAP_SIDE;
    if (!clip_axis(z, oz_sh, ez_sh, ez_sh, side, zs, ze)) return;
    if (!clip_axis(y, oy_sh, ey_sh, limy, side, ys, ye)) return;
    if (!clip_axis(x, ox_sh, ex_sh, limx, side, xs, xe)) return;
    if (zs >= ze) return;
    last_xs = xs;
    last_ys = ys;
    nz = ze - zs;
    // rounded scale, arithmetic shift floors negative products
    term = (longint'(val) * longint'(scale_sh) + 64'sd32768) >>> 16;
    add = term * nz;
    for (int yy = ys; yy < ye; yy++) begin
      for (int xx = xs; xx < xe; xx++) begin
        idx = fi * PLANE + yy * MAP_SIDE + xx;
        if (proj_mode_t'(mode_sh) == MODE_MAX) begin
          if (val > map_shadow[idx]) map_shadow[idx] = val;
        end else begin
          sum = longint'(map_shadow[idx]) + add;
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          if (sum < -64'sd2147483648) sum = -64'sd2147483648;
          map_shadow[idx] = sum[31:0];
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sender
  task automatic send_item(input opcode_t op, input int x, input int y, input int z,
                           input int lg, input int fi, input logic [31:0] val,
                           input bit chk, input logic [31:0] expv);
    int r, gap;
    gap = 0;
    if (send_gaps) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(10, 60);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    opcode <= op;
    pos_x <= x[7:0];
    pos_y <= y[7:0];
    pos_z <= z[7:0];
    size_log2 <= lg[3:0];
    field_index <= fi[1:0];
    sample_value <= val;
    do @(posedge clk); while (full);
    // item taken at this edge
    case (op)
      OP_READ: begin
        if (chk) entry_q.push_back(expv);
        else entry_q.push_back(map_shadow[fi * PLANE + y * MAP_SIDE + x]);
      end
      OP_CLEAR:   clear_shadow();
      OP_DEPOSIT: project_cell(x, y, z, lg, fi, val);
      default: ;
    endcase
  endtask

  // a read behind all earlier work; once it is back the block is idle
  task automatic drain();
    send_item(OP_READ, 0, 0, 0, 0, 0, '0, 1'b0, '0);
    push <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:  mode_sh = data[0];
      REG_ORG_X: ox_sh = data[7:0];
      REG_ORG_Y: oy_sh = data[7:0];
      REG_ORG_Z: oz_sh = data[7:0];
      REG_EXT_X: ex_sh = data[8:0];
      REG_EXT_Y: ey_sh = data[8:0];
      REG_EXT_Z: ez_sh = data[8:0];
      default:   scale_sh = data[16:0];
    endcase
  endtask

  // corner near the window, sometimes anywhere
  function automatic int pick_pos(input int org, input int ext);
    int p;
    if ($urandom_range(0, 99) < 12) return $urandom_range(0, 255);
    p = org + $urandom_range(0, (ext + 1 < 48) ? ext + 1 : 48);
    if ($urandom_range(0, 3) == 0) p = org + $urandom_range(0, ext + 1);
    return (p > 255) ? 255 : p;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h7FFF_FFFF;
    if (r < 20) return 32'h8000_0000;
    if (r < 45) return ($urandom_range(0, 1) ? 32'd0 - $urandom_range(0, 32'h40000)
                                             : $urandom_range(0, 32'h40000));
    return $urandom;
  endfunction

  task automatic random_item(input bit big);
    int r, x, y, lg;
    r = $urandom_range(0, 99);
    if (r < 56) begin
      if (big) lg = $urandom_range(0, 15);
      else lg = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      send_item(OP_DEPOSIT, pick_pos(ox_sh, ex_sh), pick_pos(oy_sh, ey_sh),
                pick_pos(oz_sh, ez_sh), lg, $urandom_range(0, 3), pick_value(),
                1'b0, '0);
    end else if (r < 97) begin
      if ($urandom_range(0, 99) < 65) begin
        x = last_xs + $urandom_range(0, 3);
        y = last_ys + $urandom_range(0, 3);
        if (x > 255) x = 255;
        if (y > 255) y = 255;
      end else begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end
      send_item(OP_READ, x, y, $urandom_range(0, 255), $urandom_range(0, 15),
                $urandom_range(0, 3), $urandom, 1'b0, '0);
    end else begin
      send_item(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 3),
                $urandom, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------- receiver
  int pop_gap = 0;
  int hold_left = 0;
  logic signed [31:0] want;

  always @(posedge clk) begin
    if (pop && !empty) begin
      if (entry_q.size() == 0) begin
        $error("read_value: nothing expected, actual %h", read_value);
        errors++;
      end else begin
        want = entry_q.pop_front();
        if (read_value !== want) begin
          $error("read_value: expected %h, actual %h", want, read_value);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      // long hold-off so the block backs up and raises full
      hold_left--;
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (pop_gaps) begin
        case ($urandom_range(0, 49))
          0:         pop_gap = $urandom_range(20, 80);
          1, 2, 3,
          4, 5, 6,
          7, 8, 9,
          10, 11:    pop_gap = $urandom_range(1, 3);
          default:   pop_gap = 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  row_t   rows [17];
  phase_t phases [9];

  initial begin
    rows = '{
      '{OP_READ,      0,   0,   0,  0, 0, 32'h0,         1, 32'h0},
      '{OP_READ,    255, 255,   0,  0, 3, 32'h0,         1, 32'h0},
      '{OP_DEPOSIT,   0,   0,   0,  0, 0, 32'h7FFF_FFFF, 0, 32'h0},
      '{OP_READ,      0,   0,   0,  0, 0, 32'h0,         1, 32'h7FFF_FFFF},
      '{OP_DEPOSIT,   1,   0,   0,  0, 1, 32'h8000_0000, 0, 32'h0},
      '{OP_READ,      1,   0,   0,  0, 1, 32'h0,         1, 32'h0},
      // largest edge from the far corner: clipped to one entry
      '{OP_DEPOSIT, 255, 255, 255, 15, 3, 32'h5,         0, 32'h0},
      '{OP_READ,    255, 255,   0,  0, 3, 32'h0,         1, 32'h5},
      '{OP_DEPOSIT,  10,  20,  30,  2, 2, 32'h0001_8000, 0, 32'h0},
      '{OP_READ,     11,  21,   0,  0, 2, 32'h0,         0, 32'h0},
      '{OP_UNUSED,    5,   5,   5,  3, 0, 32'hFFFF,      0, 32'h0},
      '{OP_READ,      5,   5,   0,  0, 0, 32'h0,         1, 32'h0},
      // negative value loses against a zero entry in max mode
      '{OP_DEPOSIT,   4,   4,   4,  1, 0, 32'hFFFF_FFFF, 0, 32'h0},
      '{OP_READ,      4,   4,   0,  0, 0, 32'h0,         1, 32'h0},
      '{OP_CLEAR,     0,   0,   0,  0, 0, 32'h0,         0, 32'h0},
      '{OP_READ,      0,   0,   0,  0, 0, 32'h0,         1, 32'h0},
      '{OP_READ,     11,  21,   0,  0, 2, 32'h0,         1, 32'h0}
    };
    // mode, origin xyz, extent xyz, scale, any size, idling
    phases = '{
      '{1'b0,   0,   0,   0, 256, 256, 256,    256, 0, 1},
      '{1'b1,   0,   0,   0, 256, 256, 256,    256, 0, 0},
      '{1'b1, 100,  50,  30,  20,  40,  10,  65536, 1, 1},
      '{1'b0, 255, 255, 255,   1,   1,   1,      0, 1, 1},
      '{1'b1,   0,   0,   0, 511, 511, 511, 131071, 0, 1},
      '{1'b1,   7,   9,   3,  16,  16,   0,      0, 1, 1},
      '{1'b0,  10, 200,   5, 300,  60, 256,   1000, 0, 1},
      '{1'b1, 128,  64, 250,  12,   8,   5,  13107, 1, 0},
      '{1'b1,   0,   0,   0, 256, 256, 256,  65535, 0, 1}
    };

    mode_sh = MODE_MAX;
    ox_sh = '0; oy_sh = '0; oz_sh = '0;
    ex_sh = 9'd256; ey_sh = 9'd256; ez_sh = 9'd256;
    scale_sh = 17'd256;
    clear_shadow();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table; full stays high through the clearing sweep after reset
    foreach (rows[i])
      send_item(rows[i].op, rows[i].x, rows[i].y, rows[i].z, rows[i].lg, rows[i].fi,
                rows[i].val, rows[i].chk, rows[i].expv);

    foreach (phases[p]) begin
      drain();
      write_reg(REG_MODE,  {31'b0, phases[p].mode});
      write_reg(REG_ORG_X, phases[p].ox);
      write_reg(REG_ORG_Y, phases[p].oy);
      write_reg(REG_ORG_Z, phases[p].oz);
      write_reg(REG_EXT_X, phases[p].ex);
      write_reg(REG_EXT_Y, phases[p].ey);
      write_reg(REG_EXT_Z, phases[p].ez);
      write_reg(REG_SCALE, phases[p].scl);
      send_gaps = phases[p].gaps;
      pop_gaps = phases[p].gaps;
      if (p == 0) begin
        // back-to-back reads against a stalled receiver
        hold_req = 1'b1;
        send_gaps = 1'b0;
        for (int k = 0; k < 40; k++)
          send_item(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255), 0, 0,
                    $urandom_range(0, 3), '0, 1'b0, '0);
        send_gaps = phases[p].gaps;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) random_item(phases[p].big);
    end

    push <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
